@@ src/escaped_packet_framer_crc8_core_macros.svh @@
// ----------------------------------------------------------------------------
// escaped_packet_framer_crc8_core_macros.svh
// Assertion macros shared by the framer RTL.
// ----------------------------------------------------------------------------
`ifndef ESCAPED_PACKET_FRAMER_CRC8_CORE_MACROS_SVH
`define ESCAPED_PACKET_FRAMER_CRC8_CORE_MACROS_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define EPF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk_i, off during reset
`define EPF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/epf_pkg.sv @@
// ----------------------------------------------------------------------------
// epf_pkg
// Constants, frame type and CRC8 byte update for the packet framer.
// ----------------------------------------------------------------------------
package epf_pkg;

  localparam logic [7:0] EscMark   = 8'hC0;
  localparam logic [7:0] EndMark   = 8'hC1;
  localparam logic [7:0] StartMark = 8'hC3;
  localparam logic [7:0] CrcPoly   = 8'h2F;
  localparam logic [7:0] EscKeep   = 8'h3F;

  localparam int unsigned FrameBytes = 4;
  localparam int unsigned IdxW       = $clog2(FrameBytes);

  // up to four line bytes built from one item, byte 0 goes out first
  typedef struct packed {
    logic [FrameBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]            last_idx;
  } frame_t;

  // CRC8, MSB first, no reflection, no final xor
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] v;
    v = crc ^ data;
    for (int b = 0; b < 8; b++) begin
      if (v[7]) begin
        v = {v[6:0], 1'b0} ^ CrcPoly;
      end else begin
        v = {v[6:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

@@ src/epf_emitter.sv @@
// ----------------------------------------------------------------------------
// epf_emitter
// Holds one built frame and shifts it out one line byte per cycle while not stalled.
// ----------------------------------------------------------------------------
module epf_emitter (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  epf_pkg::frame_t frame_i,
  output logic            can_load_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      line_byte_o,
  output logic            run_last_o
);

  logic [epf_pkg::FrameBytes-1:0][7:0] buf_q, buf_d;
  logic [epf_pkg::IdxW-1:0]            rem_q, rem_d;
  logic                                vld_q, vld_d;
  logic                                take;

  assign take        = vld_q && !out_stall_i;
  assign can_load_o  = !vld_q || (take && (rem_q == '0));
  assign out_valid_o = vld_q;
  assign line_byte_o = buf_q[0];
  assign run_last_o  = (rem_q == '0);

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    vld_d = vld_q;
    if (load_i) begin
      buf_d = frame_i.bytes;
      rem_d = frame_i.last_idx;
      vld_d = 1'b1;
    end else if (take) begin
      if (rem_q == '0) begin
        vld_d = 1'b0;
      end else begin
        buf_d = {8'h00, buf_q[epf_pkg::FrameBytes-1:1]};
        rem_d = rem_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      rem_q <= '0;
    end else begin
      vld_q <= vld_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

endmodule

@@ src/escaped_packet_framer_crc8_core.sv @@
// ----------------------------------------------------------------------------
// escaped_packet_framer_crc8_core
// Byte-stuffed packet framer with running CRC8.
// ----------------------------------------------------------------------------
// Takes a packet one byte per item (header first, payload after, last item
// flagged) and produces the line byte stream: a header item gives the start
// mark C3 and the header, and restarts the CRC8 (poly 2F, init 0, MSB first)
// from the header; a payload byte updates the CRC and is sent as is, or as
// escape C0 followed by byte&3F when it equals C0, C1 or C3; a last item then
// appends the CRC and end mark C1. Header and CRC are never escaped. Each
// item yields 1 to 4 line bytes, run_last_o marking the final one. The output
// sends one line byte per cycle while out_stall_i is low; the input takes a
// new item every cycle as long as each item yields one line byte and the
// output keeps pace. An accepted item passes through the input register,
// then the frame register that feeds the output. The input register doubles
// as a skid stage, so a new item is taken while the previous frame is still
// draining.
// ----------------------------------------------------------------------------
module escaped_packet_framer_crc8_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       is_header_i,
  input  logic       is_last_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] line_byte_o,
  output logic       run_last_o
);

  `include "escaped_packet_framer_crc8_core_macros.svh"

  // input register
  logic       in_vld_q, in_vld_d;
  logic [7:0] in_data_q;
  logic       in_hdr_q;
  logic       in_last_q;

  // running CRC, only moves when a frame is handed to the emitter
  logic [7:0] crc_q, crc_d;

  logic            accept;
  logic            load;
  logic            can_load;
  logic            needs_esc;
  logic [7:0]      crc_next;
  epf_pkg::frame_t frame;

  assign in_stall_o = in_vld_q && !can_load;
  assign accept     = in_valid_i && !in_stall_o;
  assign load       = in_vld_q && can_load;

  always_comb begin
    in_vld_d = in_vld_q;
    if (accept) begin
      in_vld_d = 1'b1;
    end else if (load) begin
      in_vld_d = 1'b0;
    end
  end

  // header restarts from zero, payload continues whatever is left
  assign crc_next = epf_pkg::crc8_update(in_hdr_q ? 8'h00 : crc_q, in_data_q);
  assign crc_d    = load ? crc_next : crc_q;

  assign needs_esc = (in_data_q == epf_pkg::EscMark) ||
                     (in_data_q == epf_pkg::EndMark) ||
                     (in_data_q == epf_pkg::StartMark);

  // build the frame; the body is one or two bytes, trailer goes right after
  always_comb begin
    frame.bytes    = '0;
    frame.last_idx = '0;
    if (in_hdr_q) begin
      frame.bytes[0] = epf_pkg::StartMark;
      frame.bytes[1] = in_data_q;
      frame.last_idx = epf_pkg::IdxW'(1);
    end else if (needs_esc) begin
      frame.bytes[0] = epf_pkg::EscMark;
      frame.bytes[1] = in_data_q & epf_pkg::EscKeep;
      frame.last_idx = epf_pkg::IdxW'(1);
    end else begin
      frame.bytes[0] = in_data_q;
      frame.last_idx = '0;
    end
    if (in_last_q) begin
      if (frame.last_idx == '0) begin
        frame.bytes[1] = crc_next;
        frame.bytes[2] = epf_pkg::EndMark;
        frame.last_idx = epf_pkg::IdxW'(2);
      end else begin
        frame.bytes[2] = crc_next;
        frame.bytes[3] = epf_pkg::EndMark;
        frame.last_idx = epf_pkg::IdxW'(3);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
      crc_q    <= 8'h00;
    end else begin
      in_vld_q <= in_vld_d;
      crc_q    <= crc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_data_q <= data_byte_i;
      in_hdr_q  <= is_header_i;
      in_last_q <= is_last_i;
    end
  end

  epf_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .frame_i     (frame),
    .can_load_o  (can_load),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_byte_o (line_byte_o),
    .run_last_o  (run_last_o)
  );

  // a header frame must open with the start mark
  `EPF_ASSERT_NEXT(a_hdr_start, load && in_hdr_q, out_valid_o && line_byte_o == epf_pkg::StartMark, "header frame does not open with start mark")

  // CRC only moves when a frame is handed over
  `EPF_ASSERT_NEXT(a_crc_hold, !load, $stable(crc_q), "CRC changed without a frame load")

  // final byte taken with nothing queued leaves the output empty
  `EPF_ASSERT_NEXT(a_drain, out_valid_o && run_last_o && !out_stall_i && !in_vld_q, !out_valid_o, "output still valid after last byte drained")

  // input only stalls while an item is held in the input register
  `EPF_ASSERT_NOW(a_stall_held, in_stall_o, in_vld_q && out_valid_o, "input stalled with no work pending")

endmodule
